>>> src/rau_pkg.sv
`default_nettype none
package rau_pkg;

	localparam int OperandWidthDef = 16;
	localparam int ResultWidth = 33;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DSRC_REM = 2'd0,
		DSRC_QNUM = 2'd1,
		DSRC_QDEN = 2'd2
	} dsrc_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_FORM,
		ST_EUC_CHK,
		ST_EUC_WAIT,
		ST_QN_WAIT,
		ST_QD_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_en;
		logic [1:0] mul_step;
		logic form;
		logic div_start;
		dsrc_t div_src;
		logic euc_step;
		logic cap_num;
		logic cap_den;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic m_zero;
		logic n_zero;
		logic out_free;
	} dp_status_t;

	function automatic int calc_nw(int w);
		return (2 * w + 1 > 64) ? 64 : 2 * w + 1;
	endfunction

endpackage
`default_nettype wire

>>> src/rau_divider.sv
`default_nettype none
module rau_divider import rau_pkg::*; #(
	parameter int NW = 33
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [NW-1:0] dividend,
	input wire logic signed [NW-1:0] divisor,
	output logic done,
	output logic signed [NW-1:0] quotient,
	output logic signed [NW-1:0] remainder
);

	localparam int CW = $clog2(NW + 1);

	logic busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] dvd_q;
	logic [NW-1:0] dvs_q;
	logic qneg_q;
	logic rneg_q;
	logic [NW:0] trial;
	logic [NW:0] shifted;

	assign shifted = {rem_q, dvd_q[NW-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend[NW-1] ? NW'(-dividend) : dividend;
			dvs_q <= divisor[NW-1] ? NW'(-divisor) : divisor;
			qneg_q <= dividend[NW-1] ^ divisor[NW-1];
			rneg_q <= dividend[NW-1];
		end else if (busy_q) begin
			if (!trial[NW]) begin
				rem_q <= trial[NW-1:0];
				dvd_q <= {dvd_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[NW-1:0];
				dvd_q <= {dvd_q[NW-2:0], 1'b0};
			end
		end
	end

	// truncating signs: quotient by operand signs, remainder follows dividend
	assign quotient = qneg_q ? NW'(-dvd_q) : dvd_q;
	assign remainder = rneg_q ? NW'(-rem_q) : rem_q;

endmodule
`default_nettype wire

>>> src/rau_datapath.sv
`default_nettype none
module rau_datapath import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = OperandWidthDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire ctrl_cmd_t cmd,
	output dp_status_t status,
	input wire logic [1:0] command,
	input wire logic signed [OPERAND_WIDTH-1:0] first_numerator,
	input wire logic signed [OPERAND_WIDTH-1:0] first_denominator,
	input wire logic signed [OPERAND_WIDTH-1:0] second_numerator,
	input wire logic signed [OPERAND_WIDTH-1:0] second_denominator,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [ResultWidth-1:0] result_numerator,
	output logic signed [ResultWidth-1:0] result_denominator,
	output logic undefined_result
);

	localparam int W = OPERAND_WIDTH;
	localparam int NW = calc_nw(OPERAND_WIDTH);

	op_t op_q;
	logic signed [W-1:0] a_q, b_q, c_q, d_q;
	logic signed [W-1:0] mx, my;
	logic signed [2*W-1:0] prod;
	logic signed [NW-1:0] p0_q, p1_q, p2_q;
	logic signed [NW-1:0] num_q, den_q, n_q, m_q;
	logic signed [ResultWidth-1:0] qn_q, qd_q;
	logic signed [NW-1:0] div_a, div_b, div_quo, div_rem;

	// operand pairs: step 0 and 1 build the numerator, step 2 the denominator
	always_comb begin
		mx = a_q;
		my = d_q;
		unique case (cmd.mul_step)
			2'd0: begin
				mx = a_q;
				my = (op_q == CMD_MUL) ? c_q : d_q;
			end
			2'd1: begin
				mx = c_q;
				my = b_q;
			end
			default: begin
				mx = b_q;
				my = (op_q == CMD_DIV) ? c_q : d_q;
			end
		endcase
	end

	assign prod = mx * my;

	always_comb begin
		div_a = n_q;
		div_b = m_q;
		unique case (cmd.div_src)
			DSRC_QNUM: begin
				div_a = num_q;
				div_b = n_q;
			end
			DSRC_QDEN: begin
				div_a = den_q;
				div_b = n_q;
			end
			default: begin
				div_a = n_q;
				div_b = m_q;
			end
		endcase
	end

	rau_divider #(.NW(NW)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(div_a),
		.divisor(div_b),
		.done(status.div_done),
		.quotient(div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(command);
			a_q <= first_numerator;
			b_q <= first_denominator;
			c_q <= second_numerator;
			d_q <= second_denominator;
		end
		if (cmd.mul_en) begin
			unique case (cmd.mul_step)
				2'd0: p0_q <= NW'(prod);
				2'd1: p1_q <= NW'(prod);
				default: p2_q <= NW'(prod);
			endcase
		end
		if (cmd.form) begin
			unique case (op_q)
				CMD_ADD: begin
					num_q <= NW'(p0_q + p1_q);
					n_q <= NW'(p0_q + p1_q);
				end
				CMD_SUB: begin
					num_q <= NW'(p0_q - p1_q);
					n_q <= NW'(p0_q - p1_q);
				end
				default: begin
					num_q <= p0_q;
					n_q <= p0_q;
				end
			endcase
			den_q <= p2_q;
			m_q <= p2_q;
		end
		if (cmd.euc_step) begin
			n_q <= m_q;
			m_q <= div_rem;
		end
		if (cmd.cap_num)
			qn_q <= ResultWidth'(div_quo);
		if (cmd.cap_den)
			qd_q <= ResultWidth'(div_quo);
	end

	assign status.m_zero = (m_q == '0);
	assign status.n_zero = (n_q == '0);
	assign status.out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// gcd of zero: drop the quotients and flag the result
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (n_q == '0) begin
				result_numerator <= '0;
				result_denominator <= '0;
				undefined_result <= 1'b1;
			end else begin
				result_numerator <= qn_q;
				result_denominator <= qd_q;
				undefined_result <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/rau_ctrl.sv
`default_nettype none
module rau_ctrl import rau_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire dp_status_t status,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.div_src = DSRC_REM;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_MUL0;
				end
			end
			ST_MUL0: begin
				cmd.mul_en = 1'b1;
				cmd.mul_step = 2'd0;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_step = 2'd1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_step = 2'd2;
				state_d = ST_FORM;
			end
			ST_FORM: begin
				cmd.form = 1'b1;
				state_d = ST_EUC_CHK;
			end
			ST_EUC_CHK: begin
				if (!status.m_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_src = DSRC_REM;
					state_d = ST_EUC_WAIT;
				end else if (status.n_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_src = DSRC_QNUM;
					state_d = ST_QN_WAIT;
				end
			end
			ST_EUC_WAIT: begin
				if (status.div_done) begin
					cmd.euc_step = 1'b1;
					state_d = ST_EUC_CHK;
				end
			end
			ST_QN_WAIT: begin
				if (status.div_done) begin
					cmd.cap_num = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_src = DSRC_QDEN;
					state_d = ST_QD_WAIT;
				end
			end
			ST_QD_WAIT: begin
				if (status.div_done) begin
					cmd.cap_den = 1'b1;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

>>> src/rational_arithmetic_unit_core.sv
`default_nettype none
// channel | handshake             | payload
// in      | in_valid / in_stall   | command, first_/second_ numerator, denominator
// out     | out_valid / out_stall | result_numerator, result_denominator, undefined_result
//
// One item at a time: multiply steps, a form step, then per Euclid step a check
// and a division on NW-bit operands (NW = 2*OPERAND_WIDTH+1, capped at 64),
// then two more divisions for the reduction. The divider is bit-serial.
// Reset clears the controller and output valid; no clearing pass.
// The next item is taken once the result sits in the output register.
module rational_arithmetic_unit_core import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = OperandWidthDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] command,
	input wire logic signed [OPERAND_WIDTH-1:0] first_numerator,
	input wire logic signed [OPERAND_WIDTH-1:0] first_denominator,
	input wire logic signed [OPERAND_WIDTH-1:0] second_numerator,
	input wire logic signed [OPERAND_WIDTH-1:0] second_denominator,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [ResultWidth-1:0] result_numerator,
	output logic signed [ResultWidth-1:0] result_denominator,
	output logic undefined_result
);

	ctrl_cmd_t cmd;
	dp_status_t status;

	rau_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status(status),
		.cmd(cmd)
	);

	rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.command(command),
		.first_numerator(first_numerator),
		.first_denominator(first_denominator),
		.second_numerator(second_numerator),
		.second_denominator(second_denominator),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_numerator(result_numerator),
		.result_denominator(result_denominator),
		.undefined_result(undefined_result)
	);

endmodule
`default_nettype wire
